[design/look_at_view_matrix_defines.svh]
// ---------------------------------------------------------------------------
// look_at_view_matrix defines
// assertion macros used by the look-at view matrix queue
// ---------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LAV_ASSERT_NOW(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LAV_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

[design/lav_pkg.sv]
// ---------------------------------------------------------------------------
// lav_pkg
// types and fixed constants of the look-at view matrix block
// ---------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

  localparam int IN_W      = 32;
  localparam int DIR_W     = IN_W + 1;
  localparam int NORM_BITS = 30;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic {
    AIM_DIR    = 1'b0,
    AIM_TARGET = 1'b1
  } aim_mode_t;

  typedef struct packed {
    logic [2:0][DIR_W-1:0] dir;
    logic [2:0][IN_W-1:0]  pos;
    logic [2:0][IN_W-1:0]  up;
  } lav_item_t;

endpackage

`default_nettype wire

[design/lav_front.sv]
// ---------------------------------------------------------------------------
// lav_front
// accepts items and turns a target point into an aim direction
// ---------------------------------------------------------------------------
`default_nettype none

module lav_front (
  input  logic                              push,
  input  logic                              full,
  input  logic                              action,
  input  logic signed [lav_pkg::IN_W-1:0]   pos [3],
  input  logic signed [lav_pkg::IN_W-1:0]   aim [3],
  input  logic signed [lav_pkg::IN_W-1:0]   up  [3],
  output logic                              wr_en,
  output lav_pkg::lav_item_t                item
);

  lav_pkg::aim_mode_t mode;

  assign mode  = lav_pkg::aim_mode_t'(action);
  assign wr_en = push && !full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item.pos[i] = pos[i];
      item.up[i]  = up[i];
      case (mode)
        lav_pkg::AIM_TARGET: begin
          item.dir[i] = lav_pkg::DIR_W'(aim[i]) - lav_pkg::DIR_W'(pos[i]);
        end
        default: begin
          item.dir[i] = lav_pkg::DIR_W'(aim[i]);
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/lav_queue.sv]
// ---------------------------------------------------------------------------
// lav_queue
// short item queue between the front and the back
// ---------------------------------------------------------------------------
`default_nettype none
`include "look_at_view_matrix_defines.svh"

module lav_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  lav_pkg::lav_item_t wr_data,
  input  logic               rd_en,
  output lav_pkg::lav_item_t rd_data,
  output logic               full,
  output logic               valid
);

  lav_pkg::lav_item_t             entry [lav_pkg::QDEPTH];
  logic [lav_pkg::QPTR_W-1:0]     wr_ptr;
  logic [lav_pkg::QPTR_W-1:0]     rd_ptr;
  logic [lav_pkg::QCNT_W-1:0]     count;

  assign full    = (count == lav_pkg::QCNT_W'(lav_pkg::QDEPTH));
  assign valid   = (count != '0);
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == lav_pkg::QPTR_W'(lav_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == lav_pkg::QPTR_W'(lav_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  `LAV_ASSERT_NOW(a_no_read_empty, rd_en, count != '0, "queue read while empty")
  `LAV_ASSERT_NOW(a_no_write_full, wr_en, !full, "queue write while full")
  `LAV_ASSERT_NEXT(a_fill_step, wr_en && !rd_en, count == $past(count) + 1'b1,
    "queue count did not step up")

endmodule

`default_nettype wire

[design/lav_norm.sv]
// ---------------------------------------------------------------------------
// lav_norm
// pipelined vector normaliser: scale, sum of squares, square root, divide
// ---------------------------------------------------------------------------
`default_nettype none

module lav_norm #(
  parameter int IW = 33,
  parameter int SW = 192,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] a [3],
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [F+1:0]  r [3],
  output logic [SW-1:0]        side_out
);

  localparam int NM  = lav_pkg::NORM_BITS;
  localparam int SQW = 2 * NM + 2;
  localparam int RTW = NM + 1;
  localparam int RMW = RTW + 2;
  localparam int NW  = NM + 1 + F;
  localparam int PW  = $clog2(IW);
  localparam int QW  = F + 1;
  localparam int BW  = F + 2;
  localparam int DN  = F + 1;

  // magnitudes and signs
  logic          v1;
  logic [IW-1:0] mag1 [3];
  logic          neg1 [3];
  logic [SW-1:0] side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= a[i][IW-1];
        mag1[i] <= a[i][IW-1] ? IW'(-a[i]) : IW'(a[i]);
      end
      side1 <= side_in;
    end
  end

  // largest magnitude
  logic          v2;
  logic [IW-1:0] mag2 [3];
  logic          neg2 [3];
  logic [IW-1:0] m2;
  logic [SW-1:0] side2;
  logic [IW-1:0] m_n;

  always_comb begin
    m_n = mag1[0];
    if (mag1[1] > m_n) m_n = mag1[1];
    if (mag1[2] > m_n) m_n = mag1[2];
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2  <= mag1;
      neg2  <= neg1;
      m2    <= m_n;
      side2 <= side1;
    end
  end

  // leading one of the largest magnitude
  logic          v3;
  logic [IW-1:0] mag3 [3];
  logic          neg3 [3];
  logic [PW-1:0] p3;
  logic          zero3;
  logic [SW-1:0] side3;
  logic [PW-1:0] p_n;

  always_comb begin
    p_n = '0;
    for (int b = 0; b < IW; b++) begin
      if (m2[b]) p_n = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag3  <= mag2;
      neg3  <= neg2;
      p3    <= p_n;
      zero3 <= (m2 == '0);
      side3 <= side2;
    end
  end

  // scale so the largest lies in [2^29, 2^30)
  logic          v4;
  logic [NM-1:0] nm4 [3];
  logic          neg4 [3];
  logic          zero4;
  logic [SW-1:0] side4;
  logic [NM-1:0] nm_n [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p3 >= PW'(NM - 1)) nm_n[i] = NM'(mag3[i] >> (p3 - PW'(NM - 1)));
      else nm_n[i] = NM'(mag3[i]) << (PW'(NM - 1) - p3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm4   <= nm_n;
      neg4  <= neg3;
      zero4 <= zero3;
      side4 <= side3;
    end
  end

  // squares
  logic            v5;
  logic [2*NM-1:0] sq5 [3];
  logic [NM-1:0]   nm5 [3];
  logic            neg5 [3];
  logic            zero5;
  logic [SW-1:0]   side5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq5[i] <= nm4[i] * nm4[i];
      nm5   <= nm4;
      neg5  <= neg4;
      zero5 <= zero4;
      side5 <= side4;
    end
  end

  // square root pipeline, one root bit per stage; index 0 holds the sum
  logic           sq_v    [RTW+1];
  logic [SQW-1:0] sq_x    [RTW+1];
  logic [RMW-1:0] sq_rem  [RTW+1];
  logic [RTW-1:0] sq_root [RTW+1];
  logic [NM-1:0]  sq_nm   [RTW+1][3];
  logic           sq_neg  [RTW+1][3];
  logic           sq_zero [RTW+1];
  logic [SW-1:0]  sq_side [RTW+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x[0]    <= SQW'(sq5[0]) + SQW'(sq5[1]) + SQW'(sq5[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_nm[0]   <= nm5;
      sq_neg[0]  <= neg5;
      sq_zero[0] <= zero5;
      sq_side[0] <= side5;
    end
  end

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    logic [RMW+1:0] t;
    logic [RMW+1:0] trial;
    logic           take;

    assign t     = {sq_rem[j], sq_x[j][SQW-1 -: 2]};
    assign trial = (RMW + 2)'({sq_root[j], 2'b01});
    assign take  = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (en) sq_v[j+1] <= sq_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x[j+1]    <= sq_x[j] << 2;
        sq_rem[j+1]  <= take ? RMW'(t - trial) : RMW'(t);
        sq_root[j+1] <= {sq_root[j][RTW-2:0], take};
        sq_nm[j+1]   <= sq_nm[j];
        sq_neg[j+1]  <= sq_neg[j];
        sq_zero[j+1] <= sq_zero[j];
        sq_side[j+1] <= sq_side[j];
      end
    end
  end

  // restoring divide, one quotient bit per stage; index 0 holds the numerators
  logic           dv_v    [DN+1];
  logic [NW-1:0]  dv_r    [DN+1][3];
  logic [QW-1:0]  dv_q    [DN+1][3];
  logic [RTW-1:0] dv_len  [DN+1];
  logic           dv_neg  [DN+1][3];
  logic           dv_zero [DN+1];
  logic [SW-1:0]  dv_side [DN+1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[RTW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_r[0][i] <= (NW'(sq_nm[RTW][i]) << F) + NW'(sq_root[RTW] >> 1);
        dv_q[0][i] <= '0;
      end
      dv_len[0]  <= sq_root[RTW];
      dv_neg[0]  <= sq_neg[RTW];
      dv_zero[0] <= sq_zero[RTW];
      dv_side[0] <= sq_side[RTW];
    end
  end

  for (genvar j = 0; j < DN; j++) begin : g_div
    logic [NW-1:0] dvs;

    assign dvs = NW'(dv_len[j]) << (F - j);

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_r[j][i] >= dvs) begin
            dv_r[j+1][i] <= dv_r[j][i] - dvs;
            dv_q[j+1][i] <= {dv_q[j][i][QW-2:0], 1'b1};
          end else begin
            dv_r[j+1][i] <= dv_r[j][i];
            dv_q[j+1][i] <= {dv_q[j][i][QW-2:0], 1'b0};
          end
        end
        dv_len[j+1]  <= dv_len[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_zero[j+1] <= dv_zero[j];
        dv_side[j+1] <= dv_side[j];
      end
    end
  end

  // sign and zero vector
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_v[DN];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero[DN]) r[i] <= '0;
        else if (dv_neg[DN][i]) r[i] <= -$signed(BW'(dv_q[DN][i]));
        else r[i] <= $signed(BW'(dv_q[DN][i]));
      end
      side_out <= dv_side[DN];
    end
  end

endmodule

`default_nettype wire

[design/lav_back.sv]
// ---------------------------------------------------------------------------
// lav_back
// basis and translation pipeline behind the item queue
// ---------------------------------------------------------------------------
`default_nettype none

module lav_back #(
  parameter int F = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  lav_pkg::lav_item_t              q_item,
  output logic                            q_rd,
  input  logic                            pop,
  output logic                            out_valid,
  output logic signed [F+1:0]             right [3],
  output logic signed [F+1:0]             vert  [3],
  output logic signed [F+1:0]             fwd   [3],
  output logic signed [lav_pkg::IN_W-1:0] shift [3]
);

  localparam int IW  = lav_pkg::IN_W;
  localparam int BW  = F + 2;
  localparam int CW  = BW + IW + 1;
  localparam int VCW = 2 * BW + 1;
  localparam int DW  = BW + IW + 2;
  localparam int S1W = 6 * IW;
  localparam int S2W = 3 * BW + 3 * IW;

  localparam logic signed [VCW-1:0] HALF_V = VCW'(64'sd1 <<< (F - 1));
  localparam logic signed [DW-1:0]  HALF_D = DW'(64'sd1 <<< (F - 1));
  localparam logic signed [VCW-1:0] LIM    = VCW'(64'sd1 <<< F);
  localparam logic signed [DW:0]    SMAX   = (DW + 1)'(64'sd2147483647);
  localparam logic signed [DW:0]    SMIN   = -SMAX - 1;

  function automatic logic signed [IW-1:0] neg_sat(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] rd;
    logic signed [DW:0]   t;
    rd = (x + HALF_D) >>> F;
    t  = -(DW + 1)'(rd);
    if (t > SMAX) t = SMAX;
    if (t < SMIN) t = SMIN;
    return IW'(t);
  endfunction

  logic en;

  assign en   = !out_valid || pop;
  assign q_rd = en && q_valid;

  // forward vector
  localparam int DIR_WL = lav_pkg::DIR_W;
  logic signed [DIR_WL-1:0] n1_a [3];
  logic signed [BW-1:0]     w1 [3];
  logic [S1W-1:0]           n1_side;
  logic                     n1_v;

  always_comb begin
    for (int i = 0; i < 3; i++) n1_a[i] = $signed(q_item.dir[i]);
  end

  lav_norm #(.IW(DIR_WL), .SW(S1W), .F(F)) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .a         (n1_a),
    .side_in   ({q_item.pos, q_item.up}),
    .out_valid (n1_v),
    .r         (w1),
    .side_out  (n1_side)
  );

  // cross product w x up at full precision
  logic signed [IW-1:0]    up1 [3];
  logic signed [IW-1:0]    pos1 [3];
  logic signed [BW+IW-1:0] cp [3][2];
  logic                    cv;
  logic signed [CW-1:0]    c [3];
  logic [S2W-1:0]          c_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up1[i]  = $signed(n1_side[i*IW +: IW]);
      pos1[i] = $signed(n1_side[3*IW + i*IW +: IW]);
    end
    cp[0][0] = w1[1] * up1[2];
    cp[0][1] = w1[2] * up1[1];
    cp[1][0] = w1[2] * up1[0];
    cp[1][1] = w1[0] * up1[2];
    cp[2][0] = w1[0] * up1[1];
    cp[2][1] = w1[1] * up1[0];
  end

  always_ff @(posedge clk) begin
    if (rst) cv <= 1'b0;
    else if (en) cv <= n1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c[i] <= CW'(cp[i][0]) - CW'(cp[i][1]);
      c_side <= {w1[2], w1[1], w1[0], pos1[2], pos1[1], pos1[0]};
    end
  end

  // right vector
  logic signed [BW-1:0] u2 [3];
  logic [S2W-1:0]       n2_side;
  logic                 n2_v;

  lav_norm #(.IW(CW), .SW(S2W), .F(F)) u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv),
    .a         (c),
    .side_in   (c_side),
    .out_valid (n2_v),
    .r         (u2),
    .side_out  (n2_side)
  );

  logic signed [BW-1:0] w2 [3];
  logic signed [IW-1:0] pos2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos2[i] = $signed(n2_side[i*IW +: IW]);
      w2[i]   = $signed(n2_side[3*IW + i*BW +: BW]);
    end
  end

  // stage t1: w x u and the dot products of u and w with pos
  logic                    t1_v;
  logic signed [VCW-1:0]   t1_vc [3];
  logic signed [DW-1:0]    t1_su;
  logic signed [DW-1:0]    t1_sw;
  logic signed [BW-1:0]    t1_u [3];
  logic signed [BW-1:0]    t1_w [3];
  logic signed [IW-1:0]    t1_pos [3];
  logic signed [2*BW-1:0]  vp [3][2];
  logic signed [BW+IW-1:0] up_p [3];
  logic signed [BW+IW-1:0] wp_p [3];

  always_comb begin
    vp[0][0] = w2[1] * u2[2];
    vp[0][1] = w2[2] * u2[1];
    vp[1][0] = w2[2] * u2[0];
    vp[1][1] = w2[0] * u2[2];
    vp[2][0] = w2[0] * u2[1];
    vp[2][1] = w2[1] * u2[0];
    for (int i = 0; i < 3; i++) begin
      up_p[i] = u2[i] * pos2[i];
      wp_p[i] = w2[i] * pos2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) t1_v <= 1'b0;
    else if (en) t1_v <= n2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) t1_vc[i] <= VCW'(vp[i][0]) - VCW'(vp[i][1]);
      t1_su  <= DW'(up_p[0]) + DW'(up_p[1]) + DW'(up_p[2]);
      t1_sw  <= DW'(wp_p[0]) + DW'(wp_p[1]) + DW'(wp_p[2]);
      t1_u   <= u2;
      t1_w   <= w2;
      t1_pos <= pos2;
    end
  end

  // stage t2: round and clamp v, finish the u and w translations
  logic                  t2_v;
  logic signed [BW-1:0]  t2_vv [3];
  logic signed [BW-1:0]  t2_u [3];
  logic signed [BW-1:0]  t2_w [3];
  logic signed [IW-1:0]  t2_pos [3];
  logic signed [IW-1:0]  t2_tu;
  logic signed [IW-1:0]  t2_tw;
  logic signed [VCW-1:0] vr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vr[i] = (t1_vc[i] + HALF_V) >>> F;
      if (vr[i] > LIM) vr[i] = LIM;
      if (vr[i] < -LIM) vr[i] = -LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) t2_v <= 1'b0;
    else if (en) t2_v <= t1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) t2_vv[i] <= BW'(vr[i]);
      t2_u   <= t1_u;
      t2_w   <= t1_w;
      t2_pos <= t1_pos;
      t2_tu  <= neg_sat(t1_su);
      t2_tw  <= neg_sat(t1_sw);
    end
  end

  // stage t3: dot product of v
  logic                    t3_v;
  logic signed [DW-1:0]    t3_sv;
  logic signed [BW-1:0]    t3_vv [3];
  logic signed [BW-1:0]    t3_u [3];
  logic signed [BW-1:0]    t3_w [3];
  logic signed [IW-1:0]    t3_tu;
  logic signed [IW-1:0]    t3_tw;
  logic signed [BW+IW-1:0] vv_p [3];

  always_comb begin
    for (int i = 0; i < 3; i++) vv_p[i] = t2_vv[i] * t2_pos[i];
  end

  always_ff @(posedge clk) begin
    if (rst) t3_v <= 1'b0;
    else if (en) t3_v <= t2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_sv <= DW'(vv_p[0]) + DW'(vv_p[1]) + DW'(vv_p[2]);
      t3_vv <= t2_vv;
      t3_u  <= t2_u;
      t3_w  <= t2_w;
      t3_tu <= t2_tu;
      t3_tw <= t2_tw;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= t3_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      right    <= t3_u;
      vert     <= t3_vv;
      fwd      <= t3_w;
      shift[0] <= t3_tu;
      shift[1] <= neg_sat(t3_sv);
      shift[2] <= t3_tw;
    end
  end

endmodule

`default_nettype wire

[design/look_at_view_matrix.sv]
// ---------------------------------------------------------------------------
// look_at_view_matrix
// look-at camera basis and translation; while pop keeps up, one item per cycle
// ---------------------------------------------------------------------------
// usage:
//   input side is a queue write: an item is taken on a clock edge with push
//   high and full low. action 1 means aim is a target point, 0 a direction.
//   result side is a queue read: while empty is low the oldest result sits
//   on the result ports, and it is taken on an edge with pop high.
// throughput: one item per cycle sustained while pop keeps up; the rate is
//   set by the fully pipelined back end (square root and divide take one
//   bit per stage, each normaliser is FRAC_BITS + 40 stages deep).
// path: an accepted item goes through the queue, the forward normaliser,
//   the cross register, the right normaliser and t1 to t3 before empty drops.
// stalls: when a result waits and pop is low, the whole back pipeline
//   holds; the two-entry front queue keeps taking items until it is full,
//   then full stays high until the back moves again.
// reset: rst is synchronous; it empties the queue and clears every valid
//   bit, so empty is high and full low right after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  action,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic signed [31:0]    aim_x,
  input  logic signed [31:0]    aim_y,
  input  logic signed [31:0]    aim_z,
  input  logic signed [31:0]    up_x,
  input  logic signed [31:0]    up_y,
  input  logic signed [31:0]    up_z,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [FRAC_BITS+1:0] right_x,
  output logic signed [FRAC_BITS+1:0] right_y,
  output logic signed [FRAC_BITS+1:0] right_z,
  output logic signed [FRAC_BITS+1:0] vert_x,
  output logic signed [FRAC_BITS+1:0] vert_y,
  output logic signed [FRAC_BITS+1:0] vert_z,
  output logic signed [FRAC_BITS+1:0] fwd_x,
  output logic signed [FRAC_BITS+1:0] fwd_y,
  output logic signed [FRAC_BITS+1:0] fwd_z,
  output logic signed [31:0]    shift_u,
  output logic signed [31:0]    shift_v,
  output logic signed [31:0]    shift_w
);

  // front: take the item, form the aim direction
  logic                           wr_en;
  lav_pkg::lav_item_t             wr_item;
  logic signed [lav_pkg::IN_W-1:0] pos_v [3];
  logic signed [lav_pkg::IN_W-1:0] aim_v [3];
  logic signed [lav_pkg::IN_W-1:0] up_v  [3];

  assign pos_v = '{pos_x, pos_y, pos_z};
  assign aim_v = '{aim_x, aim_y, aim_z};
  assign up_v  = '{up_x, up_y, up_z};

  lav_front u_front (
    .push   (push),
    .full   (full),
    .action (action),
    .pos    (pos_v),
    .aim    (aim_v),
    .up     (up_v),
    .wr_en  (wr_en),
    .item   (wr_item)
  );

  // queue between the front and the back
  lav_pkg::lav_item_t q_item;
  logic               q_valid;
  logic               q_rd;

  lav_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_item),
    .rd_en   (q_rd),
    .rd_data (q_item),
    .full    (full),
    .valid   (q_valid)
  );

  // back: normalise, cross, translate
  logic                        out_valid;
  logic signed [FRAC_BITS+1:0] right_v [3];
  logic signed [FRAC_BITS+1:0] vert_v  [3];
  logic signed [FRAC_BITS+1:0] fwd_v   [3];
  logic signed [31:0]          shift_v3 [3];

  lav_back #(.F(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .right     (right_v),
    .vert      (vert_v),
    .fwd       (fwd_v),
    .shift     (shift_v3)
  );

  assign empty   = !out_valid;
  assign right_x = right_v[0];
  assign right_y = right_v[1];
  assign right_z = right_v[2];
  assign vert_x  = vert_v[0];
  assign vert_y  = vert_v[1];
  assign vert_z  = vert_v[2];
  assign fwd_x   = fwd_v[0];
  assign fwd_y   = fwd_v[1];
  assign fwd_z   = fwd_v[2];
  assign shift_u = shift_v3[0];
  assign shift_v = shift_v3[1];
  assign shift_w = shift_v3[2];

endmodule

`default_nettype wire
